@@ rtl/frm_pkg.sv @@
// Shared types, constants and register map of the formant resonator magnitude block.
package frm_pkg;

  // FFT size limits and default phase width
  localparam int MIN_FFT_LOG2   = 4;
  localparam int MAX_FFT_LOG2   = 12;
  localparam int PHASE_BITS_DEF = 24;

  // cells in the ratio divider chain (one quotient bit each, ratio may reach 2^32)
  localparam int DIV_CELLS = 33;

  // width of the sequential divider used for the coefficient setup
  localparam int SDIV_W = 50;

  // configuration port
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_CENTER      = 3'd0;
  localparam logic [2:0] REG_BANDWIDTH   = 3'd1;
  localparam logic [2:0] REG_AMPLITUDE   = 3'd2;
  localparam logic [2:0] REG_SAMPLE_RATE = 3'd3;
  localparam logic [2:0] REG_FFT_LOG2    = 3'd4;

  localparam logic [16:0] CENTER_RST      = 17'd1000;
  localparam logic [13:0] BANDWIDTH_RST   = 14'd100;
  localparam logic [15:0] AMPLITUDE_RST   = 16'd4096;
  localparam logic [17:0] SAMPLE_RATE_RST = 18'd44100;
  localparam logic [3:0]  FFT_LOG2_RST    = 4'd10;

  // fixed-point constants
  localparam logic [30:0] ONE30        = 31'h4000_0000;
  localparam logic [26:0] LOG2E_PI_Q24 = 27'd76040385;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [30:0] SIN_A1       = 31'd1686629713;
  localparam logic [30:0] SIN_A3       = 31'd693598668;
  localparam logic [30:0] SIN_A5       = 31'd85569306;
  localparam logic [30:0] SIN_A7       = 31'd5026995;
  localparam logic [30:0] SIN_A9       = 31'd172272;
  localparam logic [30:0] SIN_A11      = 31'd3864;

  // one request in flight through the divider chain
  typedef struct packed {
    logic        valid;
    logic        oor;
    logic [31:0] rem;
    logic [31:0] dvs;
    logic [32:0] quot;
  } div_t;

  // resonator coefficients held between configuration writes
  typedef struct packed {
    logic [30:0] radius;
    logic [60:0] gain_sq;
  } coef_t;

endpackage

@@ rtl/formant_resonator_magnitude.sv @@
// Top level of the formant resonator magnitude block.
//
// Each request on the input channel carries an FFT bin index; the block answers
// with the resonator magnitude at that bin (unsigned Q8.16) and a flag that is set
// for bins at or above half the FFT size, which return zero.
// Both channels use valid/ready. A new request is taken every cycle unless the
// receiver stalls or the coefficients are being recomputed. A request passes
// 17 front stages (phase, sine polynomial, denominator, normalizing shift), a
// chain of 33 divider cells, one bit of the 33-bit ratio each, and the output
// register. When the receiver stalls the whole pipeline holds and in_ready_o
// drops until the waiting result is taken.
// Configuration goes through the APB port, registers at byte address 4*index.
// After reset and after every register write the coefficients are recomputed
// by a sequencer around a bit-serial divider; no request is accepted during that
// time. Reset restores the register defaults.
module formant_resonator_magnitude #(
  parameter int PHASE_BITS = frm_pkg::PHASE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [frm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [11:0]                bin_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [23:0]                magnitude_o,
  output logic                       flagged_o
);
  import frm_pkg::*;

  logic [16:0] center_q;
  logic [13:0] bandwidth_q;
  logic [15:0] amplitude_q;
  logic [17:0] sample_rate_q;
  logic [3:0]  fft_log2_q;
  logic [2:0]  reg_idx;
  logic        wr, derive_start, busy;
  logic        adv, accept;
  coef_t       coef;
  logic [PHASE_BITS-1:0] center_phase;
  div_t        chain [0:DIV_CELLS];
  logic        head_lsb;
  logic        out_valid_q, flag_q;
  logic [23:0] mag_q;
  logic [48:0] mprod;
  logic [49:0] msum;

  // configuration registers
  assign reg_idx      = paddr[ADDR_W-1:2];
  assign wr           = psel & penable & pwrite;
  assign derive_start = wr && (reg_idx <= REG_FFT_LOG2);
  assign pready       = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q      <= CENTER_RST;
      bandwidth_q   <= BANDWIDTH_RST;
      amplitude_q   <= AMPLITUDE_RST;
      sample_rate_q <= SAMPLE_RATE_RST;
      fft_log2_q    <= FFT_LOG2_RST;
    end else if (wr) begin
      case (reg_idx)
        REG_CENTER:      center_q      <= pwdata[16:0];
        REG_BANDWIDTH:   bandwidth_q   <= pwdata[13:0];
        REG_AMPLITUDE:   amplitude_q   <= pwdata[15:0];
        REG_SAMPLE_RATE: sample_rate_q <= pwdata[17:0];
        REG_FFT_LOG2:    fft_log2_q    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER:      prdata = 32'(center_q);
      REG_BANDWIDTH:   prdata = 32'(bandwidth_q);
      REG_AMPLITUDE:   prdata = 32'(amplitude_q);
      REG_SAMPLE_RATE: prdata = 32'(sample_rate_q);
      REG_FFT_LOG2:    prdata = 32'(fft_log2_q);
      default:         prdata = 32'd0;
    endcase
  end

  // coefficient setup
  frm_derive #(.PHASE_BITS(PHASE_BITS)) u_derive (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (derive_start),
    .center_freq_i  (center_q),
    .bandwidth_i    (bandwidth_q),
    .sample_rate_i  (sample_rate_q),
    .busy_o         (busy),
    .coef_o         (coef),
    .center_phase_o (center_phase)
  );

  // pipeline moves whenever the output register is free or being drained
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !busy;
  assign accept     = in_valid_i && in_ready_o;

  frm_front #(.PHASE_BITS(PHASE_BITS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .accept_i       (accept),
    .bin_index_i    (bin_index_i),
    .fft_log2_i     (fft_log2_q),
    .coef_i         (coef),
    .center_phase_i (center_phase),
    .head_o         (chain[0]),
    .head_lsb_o     (head_lsb)
  );

  // divider chain, one quotient bit per cell
  for (genvar c = 0; c < DIV_CELLS; c++) begin : g_cell
    frm_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .nbit_i ((c == 0) ? head_lsb : 1'b0),
      .cell_i (chain[c]),
      .cell_o (chain[c+1])
    );
  end

  // scale by the amplitude and round to Q8.16
  always_comb begin
    mprod = amplitude_q * chain[DIV_CELLS].quot;
    msum  = {1'b0, mprod} + (50'd1 << 27);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain[DIV_CELLS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flag_q <= chain[DIV_CELLS].oor;
      mag_q  <= chain[DIV_CELLS].oor ? 24'd0 : 24'(msum[49:28]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign flagged_o   = flag_q;

  // an out-of-range bin always reads back as zero
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && flagged_o) |-> (magnitude_o == 24'd0))
    else $error("flagged result with nonzero magnitude");

  // no request is taken while the coefficients are recomputed
  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("request accepted during coefficient setup");

  // a waiting result holds until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(magnitude_o) && $stable(flagged_o)))
    else $error("waiting result changed before it was taken");

endmodule

@@ rtl/frm_seqdiv.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, for the coefficient setup.
module frm_seqdiv #(
  parameter int NUM_W = frm_pkg::SDIV_W,
  parameter int DEN_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [NUM_W-1:0] num_q, num_d, quot_q, quot_d;
  logic [DEN_W-1:0] den_q, den_d, rem_q, rem_d;
  logic [DEN_W:0]   trial, diff;
  logic             fits;

  // one shift-subtract step
  always_comb begin
    trial  = {rem_q, num_q[NUM_W-1]};
    diff   = trial - {1'b0, den_q};
    fits   = trial >= {1'b0, den_q};
    cnt_d  = cnt_q;
    done_d = 1'b0;
    num_d  = num_q;
    quot_d = quot_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d  = CNT_W'(NUM_W);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      num_d  = {num_q[NUM_W-2:0], 1'b0};
      quot_d = {quot_q[NUM_W-2:0], fits};
      rem_d  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  // done is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held for more than one cycle");

endmodule

@@ rtl/frm_derive.sv @@
// Coefficient setup sequencer: pole radius, its gain term and the center phase.
module frm_derive #(
  parameter int PHASE_BITS = frm_pkg::PHASE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [16:0]           center_freq_i,
  input  logic [13:0]           bandwidth_i,
  input  logic [17:0]           sample_rate_i,
  output logic                  busy_o,
  output frm_pkg::coef_t        coef_o,
  output logic [PHASE_BITS-1:0] center_phase_o
);
  import frm_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WDIV  = 4'd1;
  localparam logic [3:0] ST_WWAIT = 4'd2;
  localparam logic [3:0] ST_PDIV  = 4'd3;
  localparam logic [3:0] ST_PWAIT = 4'd4;
  localparam logic [3:0] ST_ZMUL  = 4'd5;
  localparam logic [3:0] ST_KMUL  = 4'd6;
  localparam logic [3:0] ST_KDIV  = 4'd7;
  localparam logic [3:0] ST_KWAIT = 4'd8;
  localparam logic [3:0] ST_RAD   = 4'd9;
  localparam logic [3:0] ST_GMUL  = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [3:0]            k_q, k_d;
  logic [17:0]           fs1;
  logic [40:0]           bw_prod;
  logic                  div_start, div_done;
  logic [SDIV_W-1:0]     div_num, div_quot;
  logic [17:0]           div_den;
  logic [31:0]           frac_q;
  logic [SDIV_W-33:0]    exp_q;
  logic [29:0]           z_q, y_q;
  logic [30:0]           acc_q, radius_q, q_lin;
  logic [60:0]           gain_q;
  logic [PHASE_BITS-1:0] cphase_q;
  logic [63:0]           z_prod;
  logic [60:0]           y_prod;
  logic [61:0]           g_prod;
  logic                  big;

  // divider operands
  always_comb begin
    fs1     = (sample_rate_i == '0) ? 18'd1 : sample_rate_i;
    bw_prod = bandwidth_i * LOG2E_PI_Q24;
    case (state_q)
      ST_WDIV: begin
        div_num = SDIV_W'({bw_prod, 8'd0}) + SDIV_W'(fs1[17:1]);
        div_den = fs1;
      end
      ST_PDIV: begin
        div_num = SDIV_W'({center_freq_i, {PHASE_BITS{1'b0}}}) + SDIV_W'(fs1[17:1]);
        div_den = fs1;
      end
      default: begin
        div_num = SDIV_W'(y_q);
        div_den = {14'd0, k_q};
      end
    endcase
  end

  frm_seqdiv #(.NUM_W(SDIV_W), .DEN_W(18)) u_seqdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: ;
      ST_WDIV: begin
        div_start = 1'b1;
        state_d   = ST_WWAIT;
      end
      ST_WWAIT: if (div_done) state_d = ST_PDIV;
      ST_PDIV: begin
        div_start = 1'b1;
        state_d   = ST_PWAIT;
      end
      ST_PWAIT: if (div_done) state_d = ST_ZMUL;
      ST_ZMUL: begin
        k_d     = 4'd8;
        state_d = ST_KMUL;
      end
      ST_KMUL: state_d = ST_KDIV;
      ST_KDIV: begin
        div_start = 1'b1;
        state_d   = ST_KWAIT;
      end
      ST_KWAIT: if (div_done) begin
        k_d     = k_q - 4'd1;
        state_d = (k_q == 4'd1) ? ST_RAD : ST_KMUL;
      end
      ST_RAD:  state_d = ST_GMUL;
      ST_GMUL: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (start_i) state_d = ST_WDIV;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WDIV;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // arithmetic of the exp series and gain term
  always_comb begin
    z_prod = frac_q * LN2_Q32;
    y_prod = z_q * acc_q;
    q_lin  = ONE30 - radius_q;
    g_prod = q_lin * q_lin;
    big    = exp_q > (SDIV_W-32)'(30);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WWAIT && div_done) begin
      frac_q <= div_quot[31:0];
      exp_q  <= div_quot[SDIV_W-1:32];
    end
    if (state_q == ST_PWAIT && div_done) cphase_q <= div_quot[PHASE_BITS-1:0];
    if (state_q == ST_ZMUL) begin
      z_q   <= z_prod[63:34];
      acc_q <= ONE30;
    end
    if (state_q == ST_KMUL) y_q <= y_prod[59:30];
    if (state_q == ST_KWAIT && div_done) acc_q <= ONE30 - {1'b0, div_quot[29:0]};
    if (state_q == ST_RAD) radius_q <= big ? '0 : (acc_q >> exp_q[4:0]);
    if (state_q == ST_GMUL) gain_q <= g_prod[60:0];
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign coef_o.radius  = radius_q;
  assign coef_o.gain_sq = gain_q;
  assign center_phase_o = cphase_q;

  // radius never exceeds one once settled
  a_radius_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> radius_q <= ONE30) else $error("pole radius above one");

  // series divisor stays within the degree of the series
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KDIV) |-> (k_q != 4'd0 && k_q <= 4'd8))
    else $error("series divisor out of range");

endmodule

@@ rtl/frm_front.sv @@
// Front pipeline: bin phase, sine-squared polynomial, denominator and normalizing shift.
module frm_front #(
  parameter int PHASE_BITS = frm_pkg::PHASE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  accept_i,
  input  logic [11:0]           bin_index_i,
  input  logic [3:0]            fft_log2_i,
  input  frm_pkg::coef_t        coef_i,
  input  logic [PHASE_BITS-1:0] center_phase_i,
  output frm_pkg::div_t         head_o,
  output logic                  head_lsb_o
);
  import frm_pkg::*;

  localparam int LAST = 16;
  localparam logic [30:0] POLY_C [3:6] = '{SIN_A7, SIN_A5, SIN_A3, SIN_A1};
  localparam int NORM_SH [11:16] = '{16, 8, 4, 2, 1, 1};
  localparam int NORM_TH [11:16] = '{48, 40, 36, 34, 33, 32};

  logic [LAST:0]          vld_q, oor_q;
  logic [4:0]             lg, fl;
  logic                   oor0;
  logic [11+PHASE_BITS:0] bin_wide;
  logic [PHASE_BITS-1:0]  phase;
  logic [31:0]            u;
  logic [32:0]            t_neg;
  logic [31:0]            t;
  logic [30:0]            x_q [0:6];
  logic [30:0]            x2_q [1:5];
  logic [30:0]            acc_q [2:6];
  logic [30:0]            sn_q, s_q;
  logic [60:0]            rs_q;
  logic [63:0]            nden_q [10:16];
  logic [63:0]            nnum_q [10:16];
  logic [61:0]            sq_prod, sn_prod, s_prod, rs_prod, a11_prod;
  logic [61:0]            poly_prod [3:6];
  logic [31:0]            sn_raw;
  logic [30:0]            sn_sat;
  logic [31:0]            gs, ds;
  logic                   dzero;

  // bin phase relative to the center, folded to a half angle in [0, 1]
  always_comb begin
    fl = {1'b0, fft_log2_i};
    if (fl < 5'(MIN_FFT_LOG2)) lg = 5'(MIN_FFT_LOG2);
    else if (fl > 5'(MAX_FFT_LOG2)) lg = 5'(MAX_FFT_LOG2);
    else lg = fl;
    oor0     = {5'd0, bin_index_i} >= (17'd1 << (lg - 5'd1));
    bin_wide = {bin_index_i, {PHASE_BITS{1'b0}}} >> lg;
    phase    = bin_wide[PHASE_BITS-1:0] - center_phase_i;
    u        = 32'(phase) << (32 - PHASE_BITS);
    t_neg    = 33'h1_0000_0000 - {1'b0, u};
    t        = u[31] ? t_neg[31:0] : u;
  end

  // multipliers, one per stage
  always_comb begin
    sq_prod  = x_q[0] * x_q[0];
    a11_prod = x2_q[1] * SIN_A11;
    for (int k = 3; k <= 6; k++) poly_prod[k] = x2_q[k-1] * acc_q[k-1];
    sn_prod  = x_q[6] * acc_q[6];
    sn_raw   = sn_prod[61:30];
    sn_sat   = (sn_raw > {1'b0, ONE30}) ? ONE30 : sn_raw[30:0];
    s_prod   = sn_q * sn_q;
    rs_prod  = coef_i.radius * s_q;
  end

  // stage valid and range flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAST-1:0], accept_i};
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oor_q   <= {oor_q[LAST-1:0], oor0};
      x_q[0]  <= t[31:1];
      for (int k = 1; k <= 6; k++) x_q[k] <= x_q[k-1];
      x2_q[1] <= sq_prod[60:30];
      for (int k = 2; k <= 5; k++) x2_q[k] <= x2_q[k-1];
      acc_q[2] <= SIN_A9 - a11_prod[60:30];
      for (int k = 3; k <= 6; k++) acc_q[k] <= POLY_C[k] - poly_prod[k][60:30];
      sn_q <= sn_sat;
      s_q  <= s_prod[60:30];
      rs_q <= rs_prod[60:0];
      nden_q[10] <= {3'b000, coef_i.gain_sq} + {1'b0, rs_q, 2'b00};
      nnum_q[10] <= {3'b000, coef_i.gain_sq};
      // shift both operands right until the denominator fits in 32 bits
      for (int j = 11; j <= 16; j++) begin
        if ((nden_q[j-1] >> NORM_TH[j]) != 64'd0) begin
          nden_q[j] <= nden_q[j-1] >> NORM_SH[j];
          nnum_q[j] <= nnum_q[j-1] >> NORM_SH[j];
        end else begin
          nden_q[j] <= nden_q[j-1];
          nnum_q[j] <= nnum_q[j-1];
        end
      end
    end
  end

  // hand-off to the divider chain; a zero denominator gives a ratio of one
  always_comb begin
    gs    = nnum_q[LAST][31:0];
    ds    = nden_q[LAST][31:0];
    dzero = (ds == 32'd0);
    head_o.valid = vld_q[LAST];
    head_o.oor   = oor_q[LAST];
    head_o.rem   = dzero ? 32'd0 : {1'b0, gs[31:1]};
    head_o.dvs   = dzero ? 32'd1 : ds;
    head_o.quot  = '0;
    head_lsb_o   = dzero ? 1'b1 : gs[0];
  end

endmodule

@@ rtl/frm_div_cell.sv @@
// One cell of the ratio divider chain: a single restoring shift-subtract step.
module frm_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          nbit_i,
  input  frm_pkg::div_t cell_i,
  output frm_pkg::div_t cell_o
);

  logic [32:0] trial, diff;
  logic        fits;
  logic        valid_q, oor_q;
  logic [31:0] rem_q, dvs_q;
  logic [32:0] quot_q;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {cell_i.rem, nbit_i};
    diff  = trial - {1'b0, cell_i.dvs};
    fits  = trial >= {1'b0, cell_i.dvs};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oor_q  <= cell_i.oor;
      rem_q  <= fits ? diff[31:0] : trial[31:0];
      dvs_q  <= cell_i.dvs;
      quot_q <= {cell_i.quot[31:0], fits};
    end
  end

  assign cell_o.valid = valid_q;
  assign cell_o.oor   = oor_q;
  assign cell_o.rem   = rem_q;
  assign cell_o.dvs   = dvs_q;
  assign cell_o.quot  = quot_q;

  // partial remainder always below the divisor
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> rem_q < dvs_q) else $error("partial remainder not below divisor");

endmodule
